### rtl/core/bor_pkg.sv
// bor_pkg: shared types and codes for the bounded ordered record list
// holds the entry record, the cell control group, request and status codes
// no dependencies
package bor_pkg;

    localparam int LIST_DEPTH_DEF = 64;

    localparam int REQ_W    = 3;
    localparam int ID_W     = 32;
    localparam int HANDLE_W = 32;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 7;

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD_BACK  = 3'd0,
        REQ_ADD_FRONT = 3'd1,
        REQ_POP_BACK  = 3'd2,
        REQ_FIND      = 3'd3,
        REQ_DELETE    = 3'd4,
        REQ_READ_AT   = 3'd5,
        REQ_CLEAR     = 3'd6
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_RANGE     = 3'd4
    } t_status;

    typedef struct packed {
        logic signed [ID_W-1:0] id;
        logic [HANDLE_W-1:0]    handle;
    } t_entry;

    // one move per cycle across the whole row
    typedef struct packed {
        logic rot_left;   // every cell takes its upper neighbor, top wraps to cell 0
        logic shift_up;   // every cell takes its lower neighbor, cell 0 takes the new entry
        logic close_gap;  // cells at or above the pointer take their upper neighbor
        logic write_at;   // the cell at the pointer takes the new entry
    } t_cell_ctl;

endpackage

### rtl/core/bor_cell.sv
// bor_cell: one list slot holding an id and a handle
// loads from its lower neighbor, its upper neighbor or the new entry
// depends on bor_pkg
module bor_cell #(
    parameter int AW  = 6,
    parameter int IDX = 0
) (
    input  logic               i_clk,
    input  bor_pkg::t_cell_ctl i_ctl,
    input  logic [AW-1:0]      i_ptr,
    input  bor_pkg::t_entry    i_lower,
    input  bor_pkg::t_entry    i_upper,
    input  bor_pkg::t_entry    i_new,
    output bor_pkg::t_entry    o_entry
);
    import bor_pkg::*;

    localparam logic [AW-1:0] IDX_V = AW'(IDX);

    t_entry r_entry;
    t_entry n_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.rot_left || (i_ctl.close_gap && (IDX_V >= i_ptr))) begin
            n_entry = i_upper;
        end else if (i_ctl.shift_up) begin
            n_entry = i_lower;
        end else if (i_ctl.write_at && (IDX_V == i_ptr)) begin
            n_entry = i_new;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

### rtl/core/bounded_ordered_record_list_unit.sv
// bounded_ordered_record_list_unit: ordered list of id/handle records
// controller plus a row of bor_cell slots that rotate to be searched
// depends on bor_pkg and bor_cell
//
// Requests come in on i_in_valid / o_in_stall; one result per request leaves
// on o_out_valid / i_out_stall. Both channels move an item at an edge where
// valid is high and stall is low. One request is worked at a time: o_in_stall
// is low only while the controller is idle.
// Push back, push front, clear, the unused code and requests refused at once
// (full, empty, position out of range) go from idle straight to the done state.
// Pop back, find, read at and delete rotate the whole row of LIST_DEPTH cells
// once through cell 0, one slot per cycle; a delete that hits then closes the
// gap in the shift state before the done state.
// A request is accepted again in the cycle after its result is loaded into
// the output register, so a new request may be worked while that result
// waits on a stalled receiver; a second result waits in the controller.
// Reset (i_rst_n low, synchronous) empties the list and drops any result in
// flight; slot contents are not cleared and are never read beyond the count.
module bounded_ordered_record_list_unit #(
    parameter int LIST_DEPTH = bor_pkg::LIST_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [bor_pkg::REQ_W-1:0]      i_req_type,
    input  logic signed [bor_pkg::ID_W-1:0] i_record_id,
    input  logic [bor_pkg::HANDLE_W-1:0]   i_record_handle,
    input  logic [bor_pkg::POS_W-1:0]      i_position,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [bor_pkg::STATUS_W-1:0]   o_status,
    output logic signed [bor_pkg::ID_W-1:0] o_found_id,
    output logic [bor_pkg::HANDLE_W-1:0]   o_found_handle,
    output logic [bor_pkg::COUNT_W-1:0]    o_entry_count,
    output logic                           o_list_empty,
    output logic                           o_list_full
);
    import bor_pkg::*;

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);
    localparam logic [CW-1:0] LAST_C  = CW'(LIST_DEPTH - 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_idx, n_idx;
    logic [CW-1:0]         r_tgt, n_tgt;
    logic [AW-1:0]         r_pos, n_pos;
    logic signed [ID_W-1:0] r_key, n_key;
    t_req                  r_op, n_op;
    logic                  r_hit, n_hit;
    t_status               r_res_status, n_res_status;
    t_entry                r_res, n_res;
    logic                  r_out_valid, n_out_valid;
    t_status               r_out_status;
    t_entry                r_out_res;
    logic [CW-1:0]         r_out_count;

    t_cell_ctl             w_ctl;
    logic [AW-1:0]         w_ptr;
    t_entry                w_new;
    t_entry                w_cell [LIST_DEPTH];
    t_entry                w_head;
    logic                  w_in_acc;
    logic                  w_full;
    logic                  w_empty;
    logic                  w_range_bad;
    logic                  w_match;
    logic                  w_load_out;
    logic [CW+COUNT_W-1:0] w_count_ext;
    t_req                  w_req;

    assign w_new       = '{id: i_record_id, handle: i_record_handle};
    assign w_head      = w_cell[0];
    assign w_in_acc    = i_in_valid && (r_state == S_IDLE);
    assign w_full      = (r_count == DEPTH_C);
    assign w_empty     = (r_count == '0);
    assign w_range_bad = ({{CW{1'b0}}, i_position} >= {{POS_W{1'b0}}, r_count});
    assign w_req       = t_req'(i_req_type);
    assign w_match     = ((r_op == REQ_FIND) || (r_op == REQ_DELETE)) ?
                         (w_head.id == r_key) : (r_idx == r_tgt);
    assign w_load_out  = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_tgt        = r_tgt;
        n_pos        = r_pos;
        n_key        = r_key;
        n_op         = r_op;
        n_hit        = r_hit;
        n_res_status = r_res_status;
        n_res        = r_res;
        w_ctl        = '0;
        w_ptr        = r_pos;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state      = S_DONE;
                    n_res_status = ST_OK;
                    n_res        = '0;
                    n_idx        = '0;
                    n_hit        = 1'b0;
                    n_key        = i_record_id;
                    n_op         = w_req;
                    case (w_req)
                        REQ_ADD_BACK, REQ_ADD_FRONT: begin
                            if (w_full) begin
                                n_res_status = ST_FULL;
                            end else begin
                                w_ctl.write_at = (w_req == REQ_ADD_BACK);
                                w_ctl.shift_up = (w_req == REQ_ADD_FRONT);
                                w_ptr          = r_count[AW-1:0];
                                n_count        = r_count + 1'b1;
                                n_res          = w_new;
                            end
                        end
                        REQ_POP_BACK: begin
                            if (w_empty) begin
                                n_res_status = ST_EMPTY;
                            end else begin
                                n_state = S_SCAN;
                                n_tgt   = r_count - 1'b1;
                            end
                        end
                        REQ_FIND: begin
                            n_state      = S_SCAN;
                            n_res_status = ST_NOT_FOUND;
                        end
                        REQ_DELETE: begin
                            if (w_empty) begin
                                n_res_status = ST_EMPTY;
                            end else begin
                                n_state      = S_SCAN;
                                n_res_status = ST_NOT_FOUND;
                            end
                        end
                        REQ_READ_AT: begin
                            if (w_range_bad) begin
                                n_res_status = ST_RANGE;
                            end else begin
                                n_state = S_SCAN;
                                n_tgt   = CW'(i_position);
                            end
                        end
                        REQ_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                w_ctl.rot_left = 1'b1;
                n_idx          = r_idx + 1'b1;
                if (!r_hit && (r_idx < r_count) && w_match) begin
                    n_hit        = 1'b1;
                    n_pos        = r_idx[AW-1:0];
                    n_res        = w_head;
                    n_res_status = ST_OK;
                end
                if (r_idx == LAST_C) begin
                    n_state = S_DONE;
                    if ((r_op == REQ_DELETE) && n_hit) begin
                        n_state = S_SHIFT;
                    end
                    if (r_op == REQ_POP_BACK) begin
                        n_count = r_count - 1'b1;
                    end
                end
            end
            S_SHIFT: begin
                w_ctl.close_gap = 1'b1;
                n_count         = r_count - 1'b1;
                n_state         = S_DONE;
            end
            S_DONE: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_tgt        <= n_tgt;
        r_pos        <= n_pos;
        r_key        <= n_key;
        r_op         <= n_op;
        r_hit        <= n_hit;
        r_res_status <= n_res_status;
        r_res        <= n_res;
        if (w_load_out) begin
            r_out_status <= r_res_status;
            r_out_res    <= r_res;
            r_out_count  <= r_count;
        end
    end

    for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
        bor_cell #(
            .AW  (AW),
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_ptr   (w_ptr),
            .i_lower ((g == 0) ? w_new : w_cell[(g == 0) ? 0 : g - 1]),
            .i_upper (w_cell[(g + 1) % LIST_DEPTH]),
            .i_new   (w_new),
            .o_entry (w_cell[g])
        );
    end

    assign w_count_ext    = {{COUNT_W{1'b0}}, r_out_count};
    assign o_in_stall     = (r_state != S_IDLE) || !i_rst_n;
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_found_id     = r_out_res.id;
    assign o_found_handle = r_out_res.handle;
    assign o_entry_count  = w_count_ext[COUNT_W-1:0];
    assign o_list_empty   = (r_out_count == '0);
    assign o_list_full    = (r_out_count == DEPTH_C);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("entry count above list depth");

    a_scan_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) && (r_idx != LAST_C) |=>
        (r_state == S_SCAN) && (r_idx == CW'($past(r_idx) + 1'b1)))
        else $error("scan left early or skipped a slot");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && !w_full &&
        ((i_req_type == REQ_ADD_BACK) || (i_req_type == REQ_ADD_FRONT)) |=>
        (r_count == CW'($past(r_count) + 1'b1)))
        else $error("push did not grow the list");

    a_delete_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (r_op == REQ_DELETE) && r_hit && (r_count != '0))
        else $error("gap closed without a matching delete");

endmodule

### tb/tb.sv
// tb: self-checking bench for bounded_ordered_record_list_unit
// directed table then random request mixes under four idling phases, checked by a list predictor
// depends on bor_pkg and the rtl of the list unit
`timescale 1ns / 1ps

module tb;
    import bor_pkg::*;

    localparam int LIST_DEPTH = LIST_DEPTH_DEF;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;
    localparam int DIR_N = 25;
    localparam int PHASE_ITEMS = 412;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic signed [ID_W-1:0] id;
        logic [HANDLE_W-1:0]    handle;
        logic [COUNT_W-1:0]     count;
        logic                   empty;
        logic                   full;
    } t_list_result;

    typedef struct {
        logic [REQ_W-1:0]       req;
        logic signed [ID_W-1:0] id;
        logic [HANDLE_W-1:0]    handle;
        logic [POS_W-1:0]       pos;
        bit                     typed;
        t_list_result           want;
    } t_dir_row;

    typedef enum int {
        SEQ_MIX,
        SEQ_FILL,
        SEQ_DRAIN
    } t_seq_kind;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    logic [REQ_W-1:0]       i_req_type = '0;
    logic signed [ID_W-1:0] i_record_id = '0;
    logic [HANDLE_W-1:0]    i_record_handle = '0;
    logic [POS_W-1:0]       i_position = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic [STATUS_W-1:0]    o_status;
    logic signed [ID_W-1:0] o_found_id;
    logic [HANDLE_W-1:0]    o_found_handle;
    logic [COUNT_W-1:0]     o_entry_count;
    logic                   o_list_empty;
    logic                   o_list_full;

    bounded_ordered_record_list_unit #(
        .LIST_DEPTH(LIST_DEPTH)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_req_type      (i_req_type),
        .i_record_id     (i_record_id),
        .i_record_handle (i_record_handle),
        .i_position      (i_position),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_found_id      (o_found_id),
        .o_found_handle  (o_found_handle),
        .o_entry_count   (o_entry_count),
        .o_list_empty    (o_list_empty),
        .o_list_full     (o_list_full)
    );

    always #4 i_clk = ~i_clk;

    logic signed [ID_W-1:0] list_ids [LIST_DEPTH];
    logic [HANDLE_W-1:0]    list_handles [LIST_DEPTH];
    int                     list_count = 0;

    t_list_result expected_results [$];
    t_list_result row_exp = '0;
    bit           row_has_exp = 1'b0;
    t_list_result want_r;
    t_list_result got_r;

    int n_sent = 0;
    int n_results = 0;
    int fail_count = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_request = 0;
    int hold_left = 0;
    int full_hits = 0;

    t_dir_row dir_rows [0:DIR_N-1] = '{
        '{REQ_POP_BACK,   32'sd0,        32'd0,          6'd0,  1'b1,
          '{ST_EMPTY,     32'sd0,        32'd0,          7'd0, 1'b1, 1'b0}},
        '{REQ_DELETE,     32'sd5,        32'd0,          6'd0,  1'b1,
          '{ST_EMPTY,     32'sd0,        32'd0,          7'd0, 1'b1, 1'b0}},
        '{REQ_FIND,       32'sd0,        32'd0,          6'd0,  1'b1,
          '{ST_NOT_FOUND, 32'sd0,        32'd0,          7'd0, 1'b1, 1'b0}},
        '{REQ_READ_AT,    32'sd0,        32'd0,          6'd0,  1'b1,
          '{ST_RANGE,     32'sd0,        32'd0,          7'd0, 1'b1, 1'b0}},
        '{REQ_READ_AT,    32'sd0,        32'd0,          6'd63, 1'b1,
          '{ST_RANGE,     32'sd0,        32'd0,          7'd0, 1'b1, 1'b0}},
        '{REQ_CLEAR,      32'sd0,        32'd0,          6'd0,  1'b1,
          '{ST_OK,        32'sd0,        32'd0,          7'd0, 1'b1, 1'b0}},
        '{REQ_UNUSED,     -32'sd1,       32'hffff_ffff,  6'd63, 1'b1,
          '{ST_OK,        32'sd0,        32'd0,          7'd0, 1'b1, 1'b0}},
        '{REQ_ADD_BACK,   32'h8000_0000, 32'd0,          6'd0,  1'b1,
          '{ST_OK,        32'h8000_0000, 32'd0,          7'd1, 1'b0, 1'b0}},
        '{REQ_POP_BACK,   32'sd0,        32'd0,          6'd0,  1'b1,
          '{ST_OK,        32'h8000_0000, 32'd0,          7'd0, 1'b1, 1'b0}},
        '{REQ_ADD_BACK,   32'h7fff_ffff, 32'hffff_ffff,  6'd0,  1'b1,
          '{ST_OK,        32'h7fff_ffff, 32'hffff_ffff,  7'd1, 1'b0, 1'b0}},
        '{REQ_ADD_FRONT,  32'sd0,        32'd1,          6'd0,  1'b1,
          '{ST_OK,        32'sd0,        32'd1,          7'd2, 1'b0, 1'b0}},
        '{REQ_ADD_FRONT,  -32'sd1,       32'h8000_0000,  6'd0,  1'b1,
          '{ST_OK,        -32'sd1,       32'h8000_0000,  7'd3, 1'b0, 1'b0}},
        '{REQ_ADD_BACK,   32'sd0,        32'd2,          6'd0,  1'b0, '0},
        '{REQ_FIND,       32'sd0,        32'd0,          6'd0,  1'b0, '0},
        '{REQ_READ_AT,    32'sd0,        32'd0,          6'd0,  1'b0, '0},
        '{REQ_READ_AT,    32'sd0,        32'd0,          6'd3,  1'b0, '0},
        '{REQ_READ_AT,    32'sd0,        32'd0,          6'd4,  1'b0, '0},
        '{REQ_DELETE,     32'sd0,        32'd0,          6'd0,  1'b0, '0},
        '{REQ_FIND,       32'sd0,        32'd0,          6'd0,  1'b0, '0},
        '{REQ_DELETE,     32'sd12345,    32'd0,          6'd0,  1'b0, '0},
        '{REQ_DELETE,     -32'sd1,       32'd0,          6'd0,  1'b0, '0},
        '{REQ_POP_BACK,   32'sd0,        32'd0,          6'd0,  1'b0, '0},
        '{REQ_UNUSED,     32'sd7,        32'd9,          6'd21, 1'b0, '0},
        '{REQ_CLEAR,      32'sd0,        32'd0,          6'd0,  1'b0, '0},
        '{REQ_FIND,       -32'sd1,       32'd0,          6'd0,  1'b0, '0}
    };

    function automatic t_list_result predict_list_result(
        input logic [REQ_W-1:0]       req,
        input logic signed [ID_W-1:0] key,
        input logic [HANDLE_W-1:0]    hdl,
        input logic [POS_W-1:0]       pos
    );
        t_list_result r;
        int           hit;
        int           i;
        r = '0;
        r.status = ST_OK;
        hit = list_count;
        for (i = list_count - 1; i >= 0; i--) begin
            if (list_ids[i] == key) hit = i;
        end
        case (req)
            REQ_ADD_BACK, REQ_ADD_FRONT: begin
                if (list_count >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    if (req == REQ_ADD_BACK) begin
                        list_ids[list_count] = key;
                        list_handles[list_count] = hdl;
                    end else begin
                        for (i = list_count; i > 0; i--) begin
                            list_ids[i] = list_ids[i-1];
                            list_handles[i] = list_handles[i-1];
                        end
                        list_ids[0] = key;
                        list_handles[0] = hdl;
                    end
                    list_count++;
                    r.id = key;
                    r.handle = hdl;
                end
            end
            REQ_POP_BACK: begin
                if (list_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    list_count--;
                    r.id = list_ids[list_count];
                    r.handle = list_handles[list_count];
                end
            end
            REQ_FIND: begin
                if (hit >= list_count) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    r.id = list_ids[hit];
                    r.handle = list_handles[hit];
                end
            end
            REQ_DELETE: begin
                if (list_count == 0) begin
                    r.status = ST_EMPTY;
                end else if (hit >= list_count) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    r.id = list_ids[hit];
                    r.handle = list_handles[hit];
                    for (i = hit; i + 1 < list_count; i++) begin
                        list_ids[i] = list_ids[i+1];
                        list_handles[i] = list_handles[i+1];
                    end
                    list_count--;
                end
            end
            REQ_READ_AT: begin
                if (int'(pos) >= list_count) begin
                    r.status = ST_RANGE;
                end else begin
                    r.id = list_ids[pos];
                    r.handle = list_handles[pos];
                end
            end
            REQ_CLEAR: begin
                list_count = 0;
            end
            default: begin
            end
        endcase
        r.count = list_count[COUNT_W-1:0];
        r.empty = (list_count == 0);
        r.full = (list_count >= LIST_DEPTH);
        return r;
    endfunction

    // result check first, then prediction of the item taken at this edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                n_results++;
                if (expected_results.size() == 0) begin
                    $error("result with no request waiting");
                    fail_count++;
                end else begin
                    want_r = expected_results.pop_front();
                    if (o_status !== want_r.status) begin
                        $error("status: expected %0d, got %0d", want_r.status, o_status);
                        fail_count++;
                    end
                    if (o_found_id !== want_r.id) begin
                        $error("found_id: expected %0d, got %0d", want_r.id, o_found_id);
                        fail_count++;
                    end
                    if (o_found_handle !== want_r.handle) begin
                        $error("found_handle: expected %0h, got %0h",
                               want_r.handle, o_found_handle);
                        fail_count++;
                    end
                    if (o_entry_count !== want_r.count) begin
                        $error("entry_count: expected %0d, got %0d",
                               want_r.count, o_entry_count);
                        fail_count++;
                    end
                    if (o_list_empty !== want_r.empty) begin
                        $error("list_empty: expected %0d, got %0d",
                               want_r.empty, o_list_empty);
                        fail_count++;
                    end
                    if (o_list_full !== want_r.full) begin
                        $error("list_full: expected %0d, got %0d", want_r.full, o_list_full);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                got_r = predict_list_result(i_req_type, i_record_id, i_record_handle,
                                            i_position);
                if (got_r.status == ST_FULL) full_hits++;
                expected_results.insert(expected_results.size(),
                                        row_has_exp ? row_exp : got_r);
            end
        end
    end

    // receiver side: random stall or a long hold-off
    always @(posedge i_clk) begin
        if (hold_left == 0 && hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic send_request(
        input logic [REQ_W-1:0]       req,
        input logic signed [ID_W-1:0] key,
        input logic [HANDLE_W-1:0]    hdl,
        input logic [POS_W-1:0]       pos,
        input bit                     has_exp,
        input t_list_result           want
    );
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_record_id <= key;
        i_record_handle <= hdl;
        i_position <= pos;
        row_has_exp <= has_exp;
        row_exp <= want;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        n_sent++;
    endtask

    task automatic wait_all_results();
        i_in_valid <= 1'b0;
        while (n_results < n_sent) @(posedge i_clk);
    endtask

    initial begin
        logic signed [ID_W-1:0] id_pool [16];
        int                     idle_of [4];
        int                     stall_of [4];
        int                     ph;
        int                     k;
        int                     n;
        int                     seq_len;
        int                     r;
        t_seq_kind              kind;
        logic [REQ_W-1:0]       req;
        logic signed [ID_W-1:0] key;

        idle_of = '{0, 81, 0, 20};
        stall_of = '{0, 0, 81, 20};
        id_pool[0] = 32'sd0;
        id_pool[1] = -32'sd1;
        id_pool[2] = 32'h7fff_ffff;
        id_pool[3] = 32'h8000_0000;
        for (k = 4; k < 16; k++) id_pool[k] = $urandom;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < DIR_N; k++) begin
            send_request(dir_rows[k].req, dir_rows[k].id, dir_rows[k].handle,
                         dir_rows[k].pos, dir_rows[k].typed, dir_rows[k].want);
        end
        wait_all_results();

        for (ph = 0; ph < 4; ph++) begin
            idle_pct = idle_of[ph];
            stall_pct = stall_of[ph];
            n = 0;
            while (n < PHASE_ITEMS) begin
                r = $urandom_range(9);
                kind = (r < 4) ? SEQ_FILL : (r < 7) ? SEQ_MIX : SEQ_DRAIN;
                seq_len = (kind == SEQ_FILL) ? $urandom_range(70, 110) : $urandom_range(20, 50);
                for (k = 0; k < seq_len && n < PHASE_ITEMS; k++) begin
                    if (ph == 0 && n == 100) hold_request = HOLD_CYCLES;
                    r = $urandom_range(99);
                    case (kind)
                        SEQ_FILL: begin
                            req = (r < 45) ? REQ_ADD_BACK : (r < 85) ? REQ_ADD_FRONT :
                                  (r < 89) ? REQ_POP_BACK : (r < 93) ? REQ_FIND :
                                  (r < 96) ? REQ_READ_AT : REQ_DELETE;
                        end
                        SEQ_DRAIN: begin
                            req = (r < 30) ? REQ_POP_BACK : (r < 55) ? REQ_DELETE :
                                  (r < 75) ? REQ_FIND : (r < 95) ? REQ_READ_AT :
                                  (r < 97) ? REQ_ADD_BACK : (r < 99) ? REQ_ADD_FRONT :
                                  REQ_CLEAR;
                        end
                        default: begin
                            req = (r < 20) ? REQ_ADD_BACK : (r < 35) ? REQ_ADD_FRONT :
                                  (r < 50) ? REQ_POP_BACK : (r < 65) ? REQ_FIND :
                                  (r < 78) ? REQ_DELETE : (r < 96) ? REQ_READ_AT :
                                  (r < 98) ? REQ_CLEAR : REQ_UNUSED;
                        end
                    endcase
                    key = ($urandom_range(9) < 8) ? id_pool[$urandom_range(15)] : $urandom;
                    send_request(req, key, $urandom, POS_W'($urandom_range(63)), 1'b0, '0);
                    n++;
                end
            end
            wait_all_results();
        end

        idle_pct = 0;
        stall_pct = 0;
        repeat (LIST_DEPTH + 8) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $error("%0d results never arrived", expected_results.size());
            fail_count++;
        end
        $display("%0d requests sent, %0d results checked, %0d refused on a full list",
                 n_sent, n_results, full_hits);
        $display("directed corners, fill and drain mixes, long output hold-off, four idling mixes");
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
